/* src/psrb_pkg.sv */
`timescale 1ns / 1ps
package psrb_pkg;

  // default geometry of the strip stores
  localparam int SLOTS_DEF = 8;
  localparam int STRIP_DEF = 32;
  localparam int ROWS_DEF  = 1024;
  localparam int STORE_DEPTH_DEF = SLOTS_DEF * ROWS_DEF * STRIP_DEF;
  localparam int STORE_AW_DEF    = $clog2(STORE_DEPTH_DEF);

  // fixed field widths
  localparam int ROW_W  = 10;
  localparam int COL_W  = 12;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SLOT_W = 3;
  localparam int SEAM_W = 12;
  localparam int FW_W   = 13;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = SLOT_W;
  localparam int OUT_TDATA_W = PIX_W;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 13'd1920;

  // ramp divider: quotient bits and bits resolved per pipeline stage
  localparam int QUOT_W    = CH_W;
  localparam int DIV_STEPS = 2;

endpackage

/* src/psrb_strip_ram.sv */
`timescale 1ns / 1ps
module psrb_strip_ram #(
  parameter int DEPTH = psrb_pkg::STORE_DEPTH_DEF,
  parameter int AW    = psrb_pkg::STORE_AW_DEF,
  parameter int WIDTH = psrb_pkg::PIX_W
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/psrb_blend.sv */
`timescale 1ns / 1ps
module psrb_blend #(
  parameter int STRIP = psrb_pkg::STRIP_DEF,
  parameter int SBW   = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [psrb_pkg::PIX_W-1:0]        in_pix,
  input  logic [psrb_pkg::PIX_W-1:0]        in_st,
  input  logic [$clog2(STRIP+1)-1:0]        in_j,
  input  logic [$clog2(STRIP+1)-1:0]        in_seam,
  input  logic                              in_apply,
  input  logic [SBW-1:0]                    in_sb,
  output logic                              out_vld,
  output logic [psrb_pkg::PIX_W-1:0]        out_pix,
  output logic [SBW-1:0]                    out_sb
);
  import psrb_pkg::*;

  localparam int DW  = $clog2(STRIP + 1);
  localparam int NW  = CH_W + DW;
  localparam int NST = QUOT_W / DIV_STEPS;

  logic              vld_r  [NST+1];
  logic [SBW-1:0]    sb_r   [NST+1];
  logic [QUOT_W-1:0] q_r    [NST+1][3];
  logic              byp_r  [NST];
  logic [PIX_W-1:0]  pix_r  [NST];
  logic [DW-1:0]     seam_r [NST];
  logic [NW-1:0]     rem_r  [NST][3];

  logic [NW-1:0]     num_nxt [3];

  // weighted sum p*j + s*(seam-j), never above 255*seam
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = NW'(in_pix[c*CH_W +: CH_W]) * NW'(in_j)
                 + NW'(in_st[c*CH_W +: CH_W]) * NW'(in_seam - in_j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0]   <= in_sb;
      byp_r[0]  <= !in_apply || (in_st == '0);
      pix_r[0]  <= in_pix;
      seam_r[0] <= in_seam;
      for (int c = 0; c < 3; c++) begin
        rem_r[0][c] <= num_nxt[c];
        q_r[0][c]   <= '0;
      end
    end
  end

  // restoring division, DIV_STEPS quotient bits per stage
  for (genvar s = 1; s <= NST; s++) begin : g_div
    logic [NW-1:0]     rem_nxt [3];
    logic [QUOT_W-1:0] q_nxt   [3];

    always_comb begin
      logic [NW-1:0] cmp;
      int            b;
      for (int c = 0; c < 3; c++) begin
        rem_nxt[c] = rem_r[s-1][c];
        q_nxt[c]   = q_r[s-1][c];
        for (int t = 0; t < DIV_STEPS; t++) begin
          b   = QUOT_W - 1 - ((s - 1) * DIV_STEPS + t);
          cmp = NW'(seam_r[s-1]) << b;
          if (rem_nxt[c] >= cmp) begin
            rem_nxt[c]  = rem_nxt[c] - cmp;
            q_nxt[c][b] = 1'b1;
          end
        end
        // black stored pixel or no seam region: input passes
        if (s == NST && byp_r[s-1]) begin
          q_nxt[c] = pix_r[s-1][c*CH_W +: CH_W];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sb_r[s-1];
        for (int c = 0; c < 3; c++) begin
          q_r[s][c] <= q_nxt[c];
        end
      end
    end

    if (s < NST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          byp_r[s]  <= byp_r[s-1];
          pix_r[s]  <= pix_r[s-1];
          seam_r[s] <= seam_r[s-1];
          for (int c = 0; c < 3; c++) begin
            rem_r[s][c] <= rem_nxt[c];
          end
        end
      end
    end
  end

  assign out_vld = vld_r[NST];
  assign out_pix = {q_r[NST][2], q_r[NST][1], q_r[NST][0]};
  assign out_sb  = sb_r[NST];

endmodule

/* src/panorama_seam_ramp_blender_core.sv */
`timescale 1ns / 1ps
// throughput: one word per cycle; the whole pipeline holds while an output word waits
// strip memories are read and written in the same stage, so neighbor words see each other
// reset: frame_width returns to 1920 and both strip memories are cleared one entry a cycle,
//   all SLOTS*ROWS*STRIP entries (262144 by default), with in_tready low until done
module panorama_seam_ramp_blender_core #(
  parameter int SLOTS = psrb_pkg::SLOTS_DEF,
  parameter int STRIP = psrb_pkg::STRIP_DEF,
  parameter int ROWS  = psrb_pkg::ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [psrb_pkg::IN_TDATA_W-1:0]  in_tdata,   // row, col, ch0, ch1, ch2, seam_pos
  input  logic [psrb_pkg::IN_TUSER_W-1:0]  in_tuser,   // sector_slot
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [psrb_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_ch0, out_ch1, out_ch2
  input  logic                             cfg_wr_en,
  input  logic [psrb_pkg::FW_W-1:0]        cfg_wr_data
);
  import psrb_pkg::*;

  localparam int DEPTH = SLOTS * ROWS * STRIP;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SLOTS);
  localparam int KW    = (STRIP > 1) ? $clog2(STRIP) : 1;
  localparam int DW    = $clog2(STRIP + 1);
  localparam int SBW   = PIX_W + DW + 1 + DW;

  function automatic logic [AW-1:0] store_addr(input logic [SW-1:0] s,
                                               input logic [ROW_W-1:0] r,
                                               input logic [KW-1:0] k);
    store_addr = AW'(s) * AW'(ROWS * STRIP) + AW'(r) * AW'(STRIP) + AW'(k);
  endfunction

  // configuration
  logic [FW_W-1:0] frame_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FRAME_WIDTH_RST;
    end else if (cfg_wr_en) begin
      frame_width_r <= cfg_wr_data;
    end
  end

  // clearing sweep after reset
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  logic adv;
  logic in_acc;
  logic out_vld;

  assign adv       = !out_vld || out_tready;
  assign in_tready = adv && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // stage 1: range checks, slot wrap, seam clamp
  logic [ROW_W-1:0]  row_in;
  logic [COL_W-1:0]  col_in;
  logic [PIX_W-1:0]  pix_in;
  logic [SEAM_W-1:0] seam_in;
  logic [SLOT_W-1:0] slot_in;
  logic [SLOT_W-1:0] slot_m;
  logic [SW-1:0]     slot1_nxt;
  logic              inr1_nxt;
  logic [DW-1:0]     seam1_nxt;

  assign row_in  = in_tdata[9:0];
  assign col_in  = in_tdata[21:10];
  assign pix_in  = in_tdata[45:22];
  assign seam_in = in_tdata[57:46];
  assign slot_in = in_tuser;

  always_comb begin
    slot_m = slot_in;
    if (32'(slot_m) >= SLOTS) begin
      slot_m = slot_m - SLOT_W'(SLOTS);
    end
    if (32'(slot_m) >= SLOTS) begin
      slot_m = slot_m - SLOT_W'(SLOTS);
    end
    slot1_nxt = SW'(slot_m);
    inr1_nxt  = (seam_in != '0) && ({1'b0, seam_in} < frame_width_r)
             && ({1'b0, col_in} < frame_width_r) && (FW_W'(row_in) < FW_W'(ROWS));
    seam1_nxt = (seam_in < SEAM_W'(STRIP)) ? DW'(seam_in) : DW'(STRIP);
  end

  logic              v1_r;
  logic [ROW_W-1:0]  row1_r;
  logic [COL_W-1:0]  col1_r;
  logic [PIX_W-1:0]  pix1_r;
  logic [SW-1:0]     slot1_r;
  logic              inr1_r;
  logic [DW-1:0]     seam1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row1_r  <= row_in;
      col1_r  <= col_in;
      pix1_r  <= pix_in;
      slot1_r <= slot1_nxt;
      inr1_r  <= inr1_nxt;
      seam1_r <= seam1_nxt;
    end
  end

  // stage 2: seam region bounds, head write and left region
  logic [FW_W-1:0] wms2_nxt;
  logic [FW_W-1:0] tb2_nxt;
  logic            hwe2_nxt;
  logic            left2_nxt;
  logic [KW-1:0]   lk2_nxt;
  logic [SW-1:0]   prev2_nxt;
  logic [SW-1:0]   next2_nxt;

  always_comb begin
    wms2_nxt  = frame_width_r - FW_W'(seam1_r);
    tb2_nxt   = FW_W'(col1_r) + FW_W'(STRIP);
    hwe2_nxt  = inr1_r && (col1_r < COL_W'(STRIP));
    left2_nxt = inr1_r && (FW_W'(col1_r) < FW_W'(seam1_r));
    lk2_nxt   = KW'(FW_W'(STRIP) - FW_W'(seam1_r) + FW_W'(col1_r));
    prev2_nxt = (slot1_r == '0) ? SW'(SLOTS - 1) : slot1_r - 1'b1;
    next2_nxt = (slot1_r == SW'(SLOTS - 1)) ? '0 : slot1_r + 1'b1;
  end

  logic              v2_r;
  logic [ROW_W-1:0]  row2_r;
  logic [COL_W-1:0]  col2_r;
  logic [PIX_W-1:0]  pix2_r;
  logic [SW-1:0]     slot2_r;
  logic [SW-1:0]     prev2_r;
  logic [SW-1:0]     next2_r;
  logic              inr2_r;
  logic [DW-1:0]     seam2_r;
  logic [FW_W-1:0]   wms2_r;
  logic [FW_W-1:0]   tb2_r;
  logic              hwe2_r;
  logic              left2_r;
  logic [KW-1:0]     lk2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      pix2_r  <= pix1_r;
      slot2_r <= slot1_r;
      prev2_r <= prev2_nxt;
      next2_r <= next2_nxt;
      inr2_r  <= inr1_r;
      seam2_r <= seam1_r;
      wms2_r  <= wms2_nxt;
      tb2_r   <= tb2_nxt;
      hwe2_r  <= hwe2_nxt;
      left2_r <= left2_nxt;
      lk2_r   <= lk2_nxt;
    end
  end

  // stage 3: tail write index and right region offset
  logic [FW_W-1:0] off3;
  logic            twe3_nxt;
  logic [KW-1:0]   tk3_nxt;
  logic            right3_nxt;

  always_comb begin
    off3       = FW_W'(col2_r) - wms2_r;
    twe3_nxt   = inr2_r && (tb2_r >= frame_width_r);
    tk3_nxt    = KW'(tb2_r - frame_width_r);
    right3_nxt = inr2_r && (FW_W'(col2_r) >= wms2_r);
  end

  logic              v3_r;
  logic [ROW_W-1:0]  row3_r;
  logic [PIX_W-1:0]  pix3_r;
  logic [SW-1:0]     slot3_r;
  logic [SW-1:0]     prev3_r;
  logic [SW-1:0]     next3_r;
  logic [DW-1:0]     seam3_r;
  logic              hwe3_r;
  logic [KW-1:0]     hk3_r;
  logic              twe3_r;
  logic [KW-1:0]     tk3_r;
  logic              left3_r;
  logic [KW-1:0]     lk3_r;
  logic [DW-1:0]     jl3_r;
  logic              right3_r;
  logic [DW-1:0]     jr3_r;
  logic [KW-1:0]     rk3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row3_r   <= row2_r;
      pix3_r   <= pix2_r;
      slot3_r  <= slot2_r;
      prev3_r  <= prev2_r;
      next3_r  <= next2_r;
      seam3_r  <= seam2_r;
      hwe3_r   <= hwe2_r;
      hk3_r    <= KW'(col2_r);
      twe3_r   <= twe3_nxt;
      tk3_r    <= tk3_nxt;
      left3_r  <= left2_r;
      lk3_r    <= lk2_r;
      jl3_r    <= DW'(col2_r);
      right3_r <= right3_nxt;
      jr3_r    <= DW'(off3);
      rk3_r    <= KW'(off3);
    end
  end

  // stage 4: store addresses
  logic              v4_r;
  logic [PIX_W-1:0]  pix4_r;
  logic [DW-1:0]     seam4_r;
  logic              hwe4_r;
  logic [AW-1:0]     hwa4_r;
  logic              twe4_r;
  logic [AW-1:0]     twa4_r;
  logic [AW-1:0]     tra4_r;
  logic [AW-1:0]     hra4_r;
  logic              left4_r;
  logic [DW-1:0]     jl4_r;
  logic              right4_r;
  logic [DW-1:0]     jr4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix4_r   <= pix3_r;
      seam4_r  <= seam3_r;
      hwe4_r   <= hwe3_r;
      hwa4_r   <= store_addr(slot3_r, row3_r, hk3_r);
      twe4_r   <= twe3_r;
      twa4_r   <= store_addr(slot3_r, row3_r, tk3_r);
      tra4_r   <= store_addr(prev3_r, row3_r, lk3_r);
      hra4_r   <= store_addr(next3_r, row3_r, rk3_r);
      left4_r  <= left3_r;
      jl4_r    <= jl3_r;
      right4_r <= right3_r;
      jr4_r    <= jr3_r;
    end
  end

  // stage 5: strip memory access; writes of one word land before the next word reads
  logic             head_we;
  logic             tail_we;
  logic [AW-1:0]    head_wa;
  logic [AW-1:0]    tail_wa;
  logic [PIX_W-1:0] st_wdata;
  logic [PIX_W-1:0] head_rd;
  logic [PIX_W-1:0] tail_rd;

  assign head_we  = clr_busy_r || (adv && v4_r && hwe4_r);
  assign tail_we  = clr_busy_r || (adv && v4_r && twe4_r);
  assign head_wa  = clr_busy_r ? clr_addr_r : hwa4_r;
  assign tail_wa  = clr_busy_r ? clr_addr_r : twa4_r;
  assign st_wdata = clr_busy_r ? '0 : pix4_r;

  psrb_strip_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .WIDTH (PIX_W)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_wa),
    .wdata (st_wdata),
    .re    (adv),
    .raddr (hra4_r),
    .rdata (head_rd)
  );

  psrb_strip_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .WIDTH (PIX_W)
  ) u_tail_ram (
    .clk   (clk),
    .we    (tail_we),
    .waddr (tail_wa),
    .wdata (st_wdata),
    .re    (adv),
    .raddr (tra4_r),
    .rdata (tail_rd)
  );

  logic              v5_r;
  logic [PIX_W-1:0]  pix5_r;
  logic [DW-1:0]     seam5_r;
  logic              left5_r;
  logic [DW-1:0]     jl5_r;
  logic              right5_r;
  logic [DW-1:0]     jr5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix5_r   <= pix4_r;
      seam5_r  <= seam4_r;
      left5_r  <= left4_r;
      jl5_r    <= jl4_r;
      right5_r <= right4_r;
      jr5_r    <= jr4_r;
    end
  end

  // left region against the previous slot's tail, then right region against next head
  logic             b1_vld;
  logic [PIX_W-1:0] b1_pix;
  logic [SBW-1:0]   b1_sb;
  logic [PIX_W-1:0] b1_hst;
  logic [DW-1:0]    b1_jr;
  logic             b1_right;
  logic [DW-1:0]    b1_seam;

  psrb_blend #(
    .STRIP (STRIP),
    .SBW   (SBW)
  ) u_blend_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v5_r),
    .in_pix   (pix5_r),
    .in_st    (tail_rd),
    .in_j     (jl5_r),
    .in_seam  (seam5_r),
    .in_apply (left5_r),
    .in_sb    ({head_rd, jr5_r, right5_r, seam5_r}),
    .out_vld  (b1_vld),
    .out_pix  (b1_pix),
    .out_sb   (b1_sb)
  );

  assign {b1_hst, b1_jr, b1_right, b1_seam} = b1_sb;

  psrb_blend #(
    .STRIP (STRIP),
    .SBW   (1)
  ) u_blend_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (b1_vld),
    .in_pix   (b1_pix),
    .in_st    (b1_hst),
    .in_j     (b1_jr),
    .in_seam  (b1_seam),
    .in_apply (b1_right),
    .in_sb    (1'b0),
    .out_vld  (out_vld),
    .out_pix  (out_tdata),
    .out_sb   ()
  );

  assign out_tvalid = out_vld;

endmodule

/* tb/tb_panorama_seam_ramp_blender_core.sv */
`timescale 1ns / 1ps
module tb_panorama_seam_ramp_blender_core;
  import psrb_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int STRIP        = STRIP_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int PIPE_LATENCY = 15;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CH_W-1:0]   ch0;
    logic [CH_W-1:0]   ch1;
    logic [CH_W-1:0]   ch2;
    logic [SLOT_W-1:0] slot;
    logic [SEAM_W-1:0] seam;
  } pix_item_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [FW_W-1:0]        cfg_wr_data;

  // predictor state
  logic [PIX_W-1:0] head_mem [int];
  logic [PIX_W-1:0] tail_mem [int];
  logic [FW_W-1:0]  frame_width_q;
  logic [PIX_W-1:0] expected_pix_q [$];

  int  mismatch_cnt;
  int  pixels_sent;
  int  words_checked;
  bit  tx_idle_on;
  bit  rx_idle_on;
  int  long_hold_cycles;

  panorama_seam_ramp_blender_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb_panorama_seam_ramp_blender_core failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int strip_addr(int slot, int row, int k);
    return (slot * ROWS + row) * STRIP + k;
  endfunction

  // linear ramp per channel; a black stored pixel leaves the input alone
  function automatic logic [PIX_W-1:0] ramp_blend(logic [PIX_W-1:0] p, logic [PIX_W-1:0] s,
                                                  int j, int seam);
    logic [PIX_W-1:0] r;
    int pc;
    int sc;
    if (s == '0) return p;
    for (int c = 0; c < 3; c++) begin
      pc = p[c*CH_W +: CH_W];
      sc = s[c*CH_W +: CH_W];
      r[c*CH_W +: CH_W] = CH_W'((pc * j + sc * (seam - j)) / seam);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] predict_pixel(pix_item_t it);
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] s;
    int w;
    int col;
    int row;
    int slot;
    int seam;
    int prev_slot;
    int next_slot;
    int a;
    pix  = {it.ch2, it.ch1, it.ch0};
    res  = pix;
    w    = frame_width_q;
    col  = it.col;
    row  = it.row;
    slot = it.slot % SLOTS;
    if (it.seam > 0 && it.seam < w && col < w && row < ROWS) begin
      seam      = (it.seam < STRIP) ? int'(it.seam) : STRIP;
      prev_slot = (slot + SLOTS - 1) % SLOTS;
      next_slot = (slot + 1) % SLOTS;
      if (col < STRIP) head_mem[strip_addr(slot, row, col)] = pix;
      if (col + STRIP >= w) tail_mem[strip_addr(slot, row, col + STRIP - w)] = pix;
      if (col < seam) begin
        a   = strip_addr(prev_slot, row, STRIP - seam + col);
        s   = tail_mem.exists(a) ? tail_mem[a] : '0;
        res = ramp_blend(res, s, col, seam);
      end
      if (col >= w - seam) begin
        a   = strip_addr(next_slot, row, col - (w - seam));
        s   = head_mem.exists(a) ? head_mem[a] : '0;
        res = ramp_blend(res, s, col - (w - seam), seam);
      end
    end
    return res;
  endfunction

  function automatic pix_item_t mk_pixel(int row, int col, int c0, int c1, int c2,
                                         int slot, int seam);
    pix_item_t it;
    it.row  = ROW_W'(row);
    it.col  = COL_W'(col);
    it.ch0  = CH_W'(c0);
    it.ch1  = CH_W'(c1);
    it.ch2  = CH_W'(c2);
    it.slot = SLOT_W'(slot);
    it.seam = SEAM_W'(seam);
    return it;
  endfunction

  // mostly edge-strip pixels on a few rows so stored strips get hit; some noise
  function automatic pix_item_t random_pixel(int w);
    pix_item_t it;
    int max_seam;
    max_seam = (w - 1 < 4095) ? w - 1 : 4095;
    it.row  = ($urandom_range(0, 99) < 85) ? ROW_W'($urandom_range(0, 3))
                                           : ROW_W'($urandom_range(0, 1023));
    it.slot = SLOT_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 80) begin
      it.col = $urandom_range(0, 1) ? COL_W'($urandom_range(0, STRIP - 1))
                                    : COL_W'($urandom_range(w - STRIP, w - 1));
      it.seam = ($urandom_range(0, 99) < 70) ? SEAM_W'($urandom_range(1, 40))
                                             : SEAM_W'($urandom_range(1, max_seam));
    end else begin
      it.col  = COL_W'($urandom_range(0, 4095));
      it.seam = SEAM_W'($urandom_range(0, 4095));
    end
    it.ch0 = ($urandom_range(0, 9) == 0) ? '0 : CH_W'($urandom_range(0, 255));
    it.ch1 = ($urandom_range(0, 9) == 0) ? '0 : CH_W'($urandom_range(0, 255));
    it.ch2 = ($urandom_range(0, 9) == 0) ? '0 : CH_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      it.ch0 = '0;
      it.ch1 = '0;
      it.ch2 = '0;
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the handshake
  task automatic send_pixel(input pix_item_t it);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, it.seam, it.ch2, it.ch1, it.ch0, it.col, it.row};
    in_tuser  = it.slot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_pix_q.insert(expected_pix_q.size(), predict_pixel(it));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_words();
    in_tvalid = 1'b0;
    while (expected_pix_q.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_frame_width(input int w);
    cfg_wr_en     = 1'b1;
    cfg_wr_data   = FW_W'(w);
    frame_width_q = FW_W'(w);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(random_pixel(frame_width_q));
  endtask

  task automatic test_directed_1920();
    write_frame_width(1920);
    send_pixel(mk_pixel(0, 0, 255, 0, 128, 0, 0));          // seam zero
    send_pixel(mk_pixel(0, 5, 1, 2, 3, 3, 1920));           // seam equal to width
    send_pixel(mk_pixel(0, 1919, 9, 9, 9, 1, 4095));        // seam far out of range
    send_pixel(mk_pixel(1023, 4095, 7, 8, 9, 2, 10));       // column outside frame
    send_pixel(mk_pixel(5, 1888, 200, 100, 50, 0, 32));     // tail strip of slot 0
    send_pixel(mk_pixel(5, 31, 10, 20, 30, 0, 32));         // head strip of slot 0
    send_pixel(mk_pixel(5, 1919, 60, 70, 80, 0, 32));       // tail strip, last column
    send_pixel(mk_pixel(5, 0, 0, 0, 0, 1, 32));             // left blend, j zero
    send_pixel(mk_pixel(5, 1919, 255, 255, 255, 7, 32));    // right blend, slot wraps
    send_pixel(mk_pixel(5, 0, 255, 255, 255, 1, 1));        // one-pixel seam
    send_pixel(mk_pixel(5, 16, 255, 0, 255, 1, 32));        // left blend mid ramp
    send_pixel(mk_pixel(5, 1888, 0, 0, 0, 2, 32));          // black tail strip
    send_pixel(mk_pixel(5, 0, 11, 22, 33, 3, 32));          // black stored pixel passes
    send_pixel(mk_pixel(5, 1900, 1, 254, 127, 7, 40));      // seam clipped to strip
  endtask

  task automatic test_directed_extreme_widths();
    drain_words();
    write_frame_width(64);
    send_pixel(mk_pixel(2, 0, 40, 50, 60, 4, 63));          // widest legal seam
    send_pixel(mk_pixel(2, 64, 1, 1, 1, 4, 10));            // column equals width
    send_pixel(mk_pixel(2, 10, 2, 2, 2, 4, 64));            // seam equals width
    send_pixel(mk_pixel(2, 32, 90, 91, 92, 3, 32));         // both tail store and right blend
    send_pixel(mk_pixel(2, 0, 255, 255, 255, 4, 63));       // left blend of fresh tail
    drain_words();
    write_frame_width(4096);
    send_pixel(mk_pixel(1023, 4095, 255, 255, 255, 7, 4095));
    send_pixel(mk_pixel(1023, 31, 3, 130, 250, 0, 1));
    send_pixel(mk_pixel(1023, 4095, 0, 128, 255, 7, 4095));
  endtask

  task automatic test_random_default_width();
    drain_words();
    write_frame_width(1920);
    send_random(200);
  endtask

  task automatic test_output_stall();
    long_hold_cycles = 400;
    send_random(80);
    // let the block empty completely before going on
    drain_words();
    send_random(30);
  endtask

  task automatic test_random_widths();
    drain_words();
    write_frame_width(64);
    send_random(110);
    drain_words();
    write_frame_width(4096);
    send_random(110);
    drain_words();
    write_frame_width($urandom_range(65, 4095));
    send_random(70);
  endtask

  task automatic test_no_idle();
    drain_words();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_frame_width(FW_W'($urandom_range(64, 300)));
    send_random(50);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // result sink: random stalls plus one long hold counted here
  initial begin
    int gap;
    int hold_left;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_left  = long_hold_cycles;
        while (hold_left > 1) begin
          @(negedge clk);
          hold_left--;
        end
        long_hold_cycles = 0;
      end else begin
        gap = rx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
          out_tready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          out_tready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [PIX_W-1:0] exp_pix;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pix_q.size() == 0) begin
        $display("%0t: word with nothing expected, actual %h", $time, out_tdata);
        mismatch_cnt++;
      end else begin
        exp_pix = expected_pix_q.pop_front();
        words_checked++;
        for (int c = 0; c < 3; c++) begin
          if (out_tdata[c*CH_W +: CH_W] !== exp_pix[c*CH_W +: CH_W]) begin
            $display("%0t: out_ch%0d expected %0d actual %0d", $time, c,
                     exp_pix[c*CH_W +: CH_W], out_tdata[c*CH_W +: CH_W]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    frame_width_q    = FRAME_WIDTH_RST;
    mismatch_cnt     = 0;
    pixels_sent      = 0;
    words_checked    = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    long_hold_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // strip memories are cleared after reset with the input held off
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);

    test_directed_1920();
    test_directed_extreme_widths();
    test_random_default_width();
    test_output_stall();
    test_random_widths();
    test_no_idle();

    drain_words();
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    $display("run: %0d pixels sent, %0d words checked over widths 64, 1920, 4096 and random,",
             pixels_sent, words_checked);
    $display("     with edge strip blends, pass-through cases, a long output stall and a drain");
    if (mismatch_cnt == 0 && expected_pix_q.size() == 0) begin
      $display("tb_panorama_seam_ramp_blender_core passed");
    end else begin
      $display("tb_panorama_seam_ramp_blender_core failed");
    end
    $finish;
  end

endmodule
